@@ rtl/cdsf_pkg.sv @@
// ----------------------------------------------------------------------------
// cdsf_pkg
// shared types and constants of the sector data fifo
// ----------------------------------------------------------------------------
package cdsf_pkg;

    localparam int FIFO_BYTES_DEF       = 4096;
    localparam int SECTOR_BYTES_MAX_DEF = 4096;

    // pad byte positions
    localparam int WHOLE_LEN      = 32'h924;
    localparam int WHOLE_PAD_BACK = 4;
    localparam int DATA_LEN       = 32'h800;
    localparam int DATA_PAD_BACK  = 8;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 48;
    localparam int COUNT_W    = 13;

    typedef enum logic [2:0] {
        OP_PUSH        = 3'd0,
        OP_RD_BYTE     = 3'd1,
        OP_RD_WORD     = 3'd2,
        OP_EN_READ     = 3'd3,
        OP_LOAD_NEXT   = 3'd4,
        OP_ACCEPT_KEEP = 3'd5,
        OP_WR_ENABLE   = 3'd6,
        OP_NOP         = 3'd7
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic       last;
        logic       enable;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COPY,
        ST_RD_ISSUE,
        ST_RD_DATA,
        ST_EMIT
    } back_state_t;

endpackage

@@ rtl/cdsf_front.sv @@
// ----------------------------------------------------------------------------
// cdsf_front
// input beat register and command decode
// ----------------------------------------------------------------------------
module cdsf_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [cdsf_pkg::IN_DATA_W-1:0]  in_data,
    input  logic                            in_last,
    input  logic [2:0]                      in_opcode,
    output logic                            cmd_valid,
    input  logic                            cmd_ready,
    output cdsf_pkg::cmd_t                  cmd
);
    import cdsf_pkg::*;

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;

    assign in_ready  = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_comb
    begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        if (in_ready)
        begin
            valid_next      = in_valid;
            // every 3-bit code is an opcode, the unused one is a no-op
            cmd_next.op     = op_t'(in_opcode);
            cmd_next.data   = in_data[7:0];
            cmd_next.enable = in_data[8];
            cmd_next.last   = in_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

@@ rtl/cdsf_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// cdsf_cmd_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module cdsf_cmd_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  cdsf_pkg::cmd_t wr_cmd,
    output logic           rd_valid,
    input  logic           rd_ready,
    output cdsf_pkg::cmd_t rd_cmd
);
    import cdsf_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_wr;
    logic       do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_cmd   = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_rd)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 2'd1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_cmd;
    end

endmodule

@@ rtl/cdsf_back.sv @@
// ----------------------------------------------------------------------------
// cdsf_back
// sector store, data fifo, copy sweep and read sequencer
// ----------------------------------------------------------------------------
module cdsf_back
#(
    parameter int FIFO_BYTES       = cdsf_pkg::FIFO_BYTES_DEF,
    parameter int SECTOR_BYTES_MAX = cdsf_pkg::SECTOR_BYTES_MAX_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            whole_sector_mode,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  cdsf_pkg::cmd_t                  cmd,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [cdsf_pkg::OUT_DATA_W-1:0] out_data
);
    import cdsf_pkg::*;

    localparam int MAXB = (FIFO_BYTES > SECTOR_BYTES_MAX) ? FIFO_BYTES : SECTOR_BYTES_MAX;
    localparam int CW   = $clog2(MAXB + 1);
    localparam int AAW  = $clog2(SECTOR_BYTES_MAX);
    localparam int FAW  = $clog2(FIFO_BYTES);

    back_state_t state_reg, state_next;

    logic [CW-1:0]  len_reg, len_next;
    logic           building_reg, building_next;
    logic [CW-1:0]  fill_reg, fill_next;
    logic [CW-1:0]  rp_reg, rp_next;
    logic [7:0]     pad_reg, pad_next;
    logic           pad_present_reg, pad_present_next;
    logic           en_reg, en_next;
    logic [31:0]    word_reg, word_next;
    logic [1:0]     pos_reg, pos_next;
    logic [1:0]     remain_reg, remain_next;
    logic [CW-1:0]  cp_idx_reg, cp_idx_next;
    logic           cp_pend_reg, cp_pend_next;
    logic [CW-1:0]  cp_pidx_reg, cp_pidx_next;
    logic [CW-1:0]  pad_idx_reg, pad_idx_next;
    logic           out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic [7:0]     active_mem [SECTOR_BYTES_MAX];
    logic [7:0]     fifo_mem   [FIFO_BYTES];
    logic [7:0]     act_rd_data_reg;
    logic [7:0]     fifo_rd_data_reg;
    logic           act_we;
    logic [AAW-1:0] act_waddr;
    logic [AAW-1:0] act_raddr;
    logic           fifo_we;
    logic [FAW-1:0] fifo_waddr;
    logic [FAW-1:0] fifo_raddr;

    logic [CW-1:0]  left;
    logic [CW-1:0]  len_base;
    logic           can_accept;
    logic           start_copy;
    logic           emit_free;
    logic [7:0]     rd_byte;
    logic           copy_done;
    logic           rd_from_fifo;

    assign left      = fill_reg - rp_reg;
    assign len_base  = building_reg ? len_reg : '0;
    assign emit_free = !out_valid_reg || out_ready;
    assign cmd_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign copy_done = cp_pend_reg && (cp_pidx_reg == len_reg - CW'(1));
    assign rd_from_fifo = (left != '0);

    // accept conditions on the command waiting in the queue
    always_comb
    begin
        can_accept = !building_reg && (len_reg != '0);
        start_copy = 1'b0;
        unique case (cmd.op)
            OP_EN_READ:     start_copy = can_accept && (left == '0);
            OP_LOAD_NEXT:   start_copy = can_accept;
            OP_ACCEPT_KEEP: start_copy = can_accept && en_reg && (left == '0);
            default:        start_copy = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if ((cmd.op == OP_RD_BYTE || cmd.op == OP_RD_WORD) && en_reg)
                        state_next = ST_RD_ISSUE;
                    else if (start_copy)
                        state_next = ST_COPY;
                    else
                        state_next = ST_EMIT;
                end
            end
            ST_COPY:
            begin
                if (copy_done)
                    state_next = ST_EMIT;
            end
            ST_RD_ISSUE:
            begin
                if (rd_from_fifo)
                    state_next = ST_RD_DATA;
                else if (remain_reg == 2'd0)
                    state_next = ST_EMIT;
            end
            ST_RD_DATA:
            begin
                state_next = (remain_reg == 2'd0) ? ST_EMIT : ST_RD_ISSUE;
            end
            ST_EMIT:
            begin
                if (emit_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        len_next         = len_reg;
        building_next    = building_reg;
        fill_next        = fill_reg;
        rp_next          = rp_reg;
        pad_next         = pad_reg;
        pad_present_next = pad_present_reg;
        en_next          = en_reg;
        word_next        = word_reg;
        pos_next         = pos_reg;
        remain_next      = remain_reg;
        cp_idx_next      = cp_idx_reg;
        cp_pend_next     = cp_pend_reg;
        cp_pidx_next     = cp_pidx_reg;
        pad_idx_next     = pad_idx_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_data_next    = out_data_reg;
        act_we           = 1'b0;
        act_waddr        = len_base[AAW-1:0];
        act_raddr        = cp_idx_reg[AAW-1:0];
        fifo_we          = 1'b0;
        fifo_waddr       = cp_pidx_reg[FAW-1:0];
        fifo_raddr       = rp_reg[FAW-1:0];
        rd_byte          = 8'd0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    word_next    = '0;
                    pos_next     = 2'd0;
                    remain_next  = (cmd.op == OP_RD_WORD) ? 2'd3 : 2'd0;
                    cp_idx_next  = '0;
                    cp_pend_next = 1'b0;
                    unique case (cmd.op)
                        OP_PUSH:
                        begin
                            len_next = len_base;
                            if (len_base < CW'(SECTOR_BYTES_MAX))
                            begin
                                act_we   = 1'b1;
                                len_next = len_base + CW'(1);
                            end
                            building_next = !cmd.last;
                        end
                        OP_EN_READ, OP_LOAD_NEXT: en_next = 1'b1;
                        OP_WR_ENABLE:             en_next = cmd.enable;
                        default:                  en_next = en_reg;
                    endcase
                    if (whole_sector_mode && len_reg >= CW'(WHOLE_LEN))
                        pad_idx_next = CW'(WHOLE_LEN - WHOLE_PAD_BACK);
                    else if (!whole_sector_mode && len_reg >= CW'(DATA_LEN))
                        pad_idx_next = CW'(DATA_LEN - DATA_PAD_BACK);
                    else
                        pad_idx_next = len_reg - CW'(1);
                end
            end
            ST_COPY:
            begin
                // one read issued and one byte landed per cycle
                if (cp_idx_reg < len_reg)
                begin
                    cp_idx_next  = cp_idx_reg + CW'(1);
                    cp_pend_next = 1'b1;
                    cp_pidx_next = cp_idx_reg;
                end
                else
                    cp_pend_next = 1'b0;
                if (cp_pend_reg)
                begin
                    fifo_we = (cp_pidx_reg < CW'(FIFO_BYTES));
                    if (cp_pidx_reg == pad_idx_reg)
                        pad_next = act_rd_data_reg;
                end
                if (copy_done)
                begin
                    rp_next          = '0;
                    fill_next        = (len_reg > CW'(FIFO_BYTES)) ? CW'(FIFO_BYTES) : len_reg;
                    pad_present_next = 1'b1;
                end
            end
            ST_RD_ISSUE:
            begin
                if (rd_from_fifo)
                    rp_next = rp_reg + CW'(1);
                else
                begin
                    rd_byte = pad_present_reg ? pad_reg : 8'd0;
                    word_next[pos_reg*8 +: 8] = rd_byte;
                    pos_next    = pos_reg + 2'd1;
                    remain_next = remain_reg - 2'd1;
                end
            end
            ST_RD_DATA:
            begin
                rd_byte = fifo_rd_data_reg;
                word_next[pos_reg*8 +: 8] = rd_byte;
                pos_next    = pos_reg + 2'd1;
                remain_next = remain_reg - 2'd1;
            end
            ST_EMIT:
            begin
                if (emit_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {2'b00, en_reg, COUNT_W'(left), word_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            len_reg         <= '0;
            building_reg    <= 1'b0;
            fill_reg        <= '0;
            rp_reg          <= '0;
            pad_reg         <= 8'd0;
            pad_present_reg <= 1'b0;
            en_reg          <= 1'b0;
            cp_pend_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            len_reg         <= len_next;
            building_reg    <= building_next;
            fill_reg        <= fill_next;
            rp_reg          <= rp_next;
            pad_reg         <= pad_next;
            pad_present_reg <= pad_present_next;
            en_reg          <= en_next;
            cp_pend_reg     <= cp_pend_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg     <= word_next;
        pos_reg      <= pos_next;
        remain_reg   <= remain_next;
        cp_idx_reg   <= cp_idx_next;
        cp_pidx_reg  <= cp_pidx_next;
        pad_idx_reg  <= pad_idx_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (act_we)
            active_mem[act_waddr] <= cmd.data;
        act_rd_data_reg <= active_mem[act_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (fifo_we)
            fifo_mem[fifo_waddr] <= act_rd_data_reg;
        fifo_rd_data_reg <= fifo_mem[fifo_raddr];
    end

endmodule

@@ rtl/cdrom_sector_data_fifo.sv @@
// ----------------------------------------------------------------------------
// cdrom_sector_data_fifo
// data side of an optical-disc controller: sector buffer and host byte fifo
// ----------------------------------------------------------------------------
// path: push and control beats pass the front register, queue, back end and
//   output register; a read takes an issue and a data state per fifo byte,
//   and only the issue state per byte past the end of the fifo
// accept: the copy sweep takes one sector byte per cycle
// throughput: one beat at a time in the back end; front and queue keep taking
//   up to three beats while it works
// reset: asynchronous, active low; clears control state, memories undefined
module cdrom_sector_data_fifo
#(
    parameter int FIFO_BYTES       = cdsf_pkg::FIFO_BYTES_DEF,
    parameter int SECTOR_BYTES_MAX = cdsf_pkg::SECTOR_BYTES_MAX_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // whole_sector_mode register
    input  logic                            cfg_wr_en,
    input  logic                            cfg_wr_data,
    // input beats
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [cdsf_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // data_byte[7:0], enable_bit[8]
    input  logic                            s_axis_tlast,  // last_byte
    input  logic [2:0]                      s_axis_tuser,  // opcode[2:0]
    // result beats
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [cdsf_pkg::OUT_DATA_W-1:0] m_axis_tdata   // read_value[31:0],
                                                           // fifo_count[44:32],
                                                           // read_enabled[45]
);
    import cdsf_pkg::*;

    logic       mode_reg;
    logic       front_valid;
    logic       front_ready;
    cmd_t       front_cmd;
    logic       q_valid;
    logic       q_ready;
    cmd_t       q_cmd;
    logic [2:0] inflight_reg;

    // config register, sampled by the back end at accept time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (cfg_wr_en)
            mode_reg <= cfg_wr_data;
    end

    // beats between input and output handshakes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= 3'd0;
        else
            inflight_reg <= inflight_reg + 3'(s_axis_tvalid && s_axis_tready)
                                         - 3'(m_axis_tvalid && m_axis_tready);
    end

    // front: register and decode each beat
    cdsf_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .in_opcode (s_axis_tuser),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    // short queue so the front keeps taking beats while the back is busy
    cdsf_cmd_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_cmd   (front_cmd),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_cmd   (q_cmd)
    );

    // back: memories, copy sweep, read sequencer and output register
    cdsf_back
    #(
        .FIFO_BYTES       (FIFO_BYTES),
        .SECTOR_BYTES_MAX (SECTOR_BYTES_MAX)
    )
    u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .whole_sector_mode (mode_reg),
        .cmd_valid         (q_valid),
        .cmd_ready         (q_ready),
        .cmd               (q_cmd),
        .out_valid         (m_axis_tvalid),
        .out_ready         (m_axis_tready),
        .out_data          (m_axis_tdata)
    );

`ifndef NO_ASSERTIONS
    // a read with reads disabled always returns zero
    a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[45] |-> m_axis_tdata[31:0] == 32'd0)
        else $error("nonzero read value while reads disabled");

    // every result belongs to an accepted beat
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> inflight_reg != 3'd0)
        else $error("result beat without an accepted input beat");

    // at most front, queue, back and output register hold beats
    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 3'd5)
        else $error("too many beats in flight");
`endif

endmodule
